>>> rtl/tscr_pkg.sv
// ----------------------------------------------------------------------------
// tscr_pkg: shared types and constants for three-shunt current reconstruction
// Field widths, fixed-point positions, function and register codes, saturation.
// ----------------------------------------------------------------------------
package tscr_pkg;

  localparam int unsigned ADC_W      = 12;  // raw ADC field width
  localparam int unsigned CUR_W      = 16;  // signed mA
  localparam int unsigned MV_W       = 16;  // unsigned mV
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned INV_W      = 3;
  localparam int unsigned SECTOR_W   = 3;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned PAIR_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned OFS_FRAC   = 4;   // offsets are Qx.4 counts
  localparam int unsigned CUR_FRAC   = 20;  // Q16 scale times Q4 diff
  localparam int unsigned BUS_FRAC   = 8;   // Q8 bus scale
  localparam int unsigned SAT_IN_W   = 40;  // width fed to the saturator

  localparam int unsigned CALIB_SAMPLES_DEF = 64;
  localparam int unsigned ADC_BITS_DEF      = 12;

  localparam logic [MV_W-1:0] VBUS_DEFAULT_RST = 16'd24000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_CALIB  = 2'd1,
    FUNC_RESET  = 2'd2
  } func_e;

  typedef enum logic [PAIR_W-1:0] {
    PAIR_VW = 2'd0,
    PAIR_UW = 2'd1,
    PAIR_UV = 2'd2
  } pair_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_SCALE = 2'd0,
    REG_PHASE_INVERT  = 2'd1,
    REG_VBUS_SCALE    = 2'd2,
    REG_VBUS_DEFAULT  = 2'd3
  } cfg_reg_e;

  // Clamp a wide signed value to the signed current range.
  function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-CUR_W:0] top;
    top = v[SAT_IN_W-1:CUR_W-1];
    if (top == '0 || top == '1) begin
      return v[CUR_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return {1'b1, {(CUR_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CUR_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/tscr_if.sv
// ----------------------------------------------------------------------------
// tscr channel interfaces
// Sample input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface tscr_in_if import tscr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ADC_W-1:0]    adc_u;
  logic [ADC_W-1:0]    adc_v;
  logic [ADC_W-1:0]    adc_w;
  logic [ADC_W-1:0]    adc_bus;
  logic                bus_ready;
  logic [SECTOR_W-1:0] sector;
  logic                fallback;

  modport source (output valid, func, adc_u, adc_v, adc_w, adc_bus, bus_ready, sector,
                  fallback, input ready);
  modport sink   (input valid, func, adc_u, adc_v, adc_w, adc_bus, bus_ready, sector,
                  fallback, output ready);
endinterface

interface tscr_out_if import tscr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CUR_W-1:0] current_u_ma;
  logic signed [CUR_W-1:0] current_v_ma;
  logic signed [CUR_W-1:0] current_w_ma;
  logic [MV_W-1:0]         bus_mv;
  logic [PAIR_W-1:0]       trusted_pair;
  logic                    held;
  logic [HOLD_W-1:0]       hold_count;
  logic                    calib_done;

  modport source (output valid, current_u_ma, current_v_ma, current_w_ma, bus_mv,
                  trusted_pair, held, hold_count, calib_done, input ready);
  modport sink   (input valid, current_u_ma, current_v_ma, current_w_ma, bus_mv,
                  trusted_pair, held, hold_count, calib_done, output ready);
endinterface

interface tscr_cfg_if import tscr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/three_shunt_current_reconstruct.sv
// ----------------------------------------------------------------------------
// three_shunt_current_reconstruct: phase currents from three shunt samples
// Offset calibration, scaling to mA, sector-based rebuild, hold, bus voltage.
// ----------------------------------------------------------------------------
// Throughput is one sample transaction per clock while results drain: the
// item lands in an input register, all arithmetic (three per-phase scale
// multipliers, the rebuild adder, the bus multiplier, the offset reciprocal
// multipliers on the last calibration sample) runs in one pass, and the
// result sits in an output register. The input side keeps taking items while
// a result waits, as long as the output register is being drained. Function
// codes: update turns samples into currents (holding the last good set on
// fallback, if one exists), calibration accumulates CALIB_SAMPLES samples and
// then latches the offsets with calib_done set, runtime reset drops the held
// set and the hold counter but keeps offsets and calibration progress.
// Calibration, reset and unused codes return all-zero results (apart from
// calib_done). Registers: 0 current_scale (Q16 mA/count), 1 phase_invert
// (bit per U,V,W), 2 vbus_scale (Q8 mV/count), 3 vbus_default_mv; write them
// only while no transaction is in flight. There is no clearing pass after
// reset. ADC_BITS masks the shunt samples to that many low bits.
// ----------------------------------------------------------------------------
module three_shunt_current_reconstruct import tscr_pkg::*; #(
  parameter int unsigned CALIB_SAMPLES = CALIB_SAMPLES_DEF,
  parameter int unsigned ADC_BITS      = ADC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tscr_cfg_if.sink     cfg_i,
  tscr_in_if.sink      in_i,
  tscr_out_if.source   out_o
);

  localparam int unsigned RAW_W   = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int unsigned OFS_W   = RAW_W + OFS_FRAC;
  localparam int unsigned BUS_P_W = ADC_W + SCALE_W + 1;
  localparam logic [BUS_P_W-1:0] BUS_ROUND = BUS_P_W'(1) << (BUS_FRAC - 1);

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ADC_W-1:0]    adc_u;
    logic [ADC_W-1:0]    adc_v;
    logic [ADC_W-1:0]    adc_w;
    logic [ADC_W-1:0]    adc_bus;
    logic                bus_ready;
    logic [SECTOR_W-1:0] sector;
    logic                fallback;
  } item_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cur_u;
    logic [CUR_W-1:0]  cur_v;
    logic [CUR_W-1:0]  cur_w;
    logic [MV_W-1:0]   mv;
    logic [PAIR_W-1:0] pair;
    logic              held;
    logic [HOLD_W-1:0] hold_count;
    logic              calib_done;
  } result_t;

  // -- configuration registers ---------------------------------------------
  logic [SCALE_W-1:0] cur_scale_q;
  logic [INV_W-1:0]   invert_q;
  logic [SCALE_W-1:0] vbus_scale_q;
  logic [MV_W-1:0]    vbus_def_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_scale_q  <= '0;
      invert_q     <= '0;
      vbus_scale_q <= '0;
      vbus_def_q   <= VBUS_DEFAULT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CURRENT_SCALE: cur_scale_q  <= cfg_i.data;
        REG_PHASE_INVERT:  invert_q     <= cfg_i.data[INV_W-1:0];
        REG_VBUS_SCALE:    vbus_scale_q <= cfg_i.data;
        REG_VBUS_DEFAULT:  vbus_def_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // -- input register --------------------------------------------------------
  item_t   in_q;
  logic    in_valid_q;
  logic    advance;       // item moves from input to output register
  result_t res_q, res_d;
  logic    out_valid_q;

  assign advance    = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= '{func: in_i.func, adc_u: in_i.adc_u, adc_v: in_i.adc_v,
                adc_w: in_i.adc_w, adc_bus: in_i.adc_bus, bus_ready: in_i.bus_ready,
                sector: in_i.sector, fallback: in_i.fallback};
    end
  end

  // -- calibration -------------------------------------------------------------
  logic [2:0][RAW_W-1:0] raw;
  logic [2:0][OFS_W-1:0] offset;
  logic                  calib_fire, calib_done;

  assign raw[0] = in_q.adc_u[RAW_W-1:0];
  assign raw[1] = in_q.adc_v[RAW_W-1:0];
  assign raw[2] = in_q.adc_w[RAW_W-1:0];
  assign calib_fire = advance && (in_q.func == FUNC_CALIB);

  tscr_calib #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .RAW_W         (RAW_W)
  ) u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (calib_fire),
    .raw_i    (raw),
    .offset_o (offset),
    .done_o   (calib_done)
  );

  // -- per-phase scaling ---------------------------------------------------------
  logic signed [CUR_W-1:0] meas [3];

  for (genvar p = 0; p < 3; p++) begin : g_phase
    tscr_phase #(
      .RAW_W (RAW_W)
    ) u_phase (
      .raw_i     (raw[p]),
      .offset_i  (offset[p]),
      .invert_i  (invert_q[p]),
      .scale_i   (cur_scale_q),
      .current_o (meas[p])
    );
  end

  // -- sector rebuild: untrusted phase is minus the sum of the other two ----------
  function automatic logic signed [CUR_W-1:0] rebuild(input logic signed [CUR_W-1:0] a,
                                                      input logic signed [CUR_W-1:0] b);
    logic signed [SAT_IN_W-1:0] s;
    s = -(SAT_IN_W'(a) + SAT_IN_W'(b));
    return sat_cur(s);
  endfunction

  logic signed [CUR_W-1:0] cur_u, cur_v, cur_w;
  pair_e                   pair;

  always_comb begin
    cur_u = meas[0];
    cur_v = meas[1];
    cur_w = meas[2];
    unique case (in_q.sector) inside
      3'd1, 3'd6: begin
        pair  = PAIR_VW;
        cur_u = rebuild(meas[1], meas[2]);
      end
      3'd2, 3'd3: begin
        pair  = PAIR_UW;
        cur_v = rebuild(meas[0], meas[2]);
      end
      default: begin   // sectors 4, 5 and out-of-range codes
        pair  = PAIR_UV;
        cur_w = rebuild(meas[0], meas[1]);
      end
    endcase
  end

  // -- bus voltage ---------------------------------------------------------------
  logic [BUS_P_W-1:0]          bus_sum;
  logic [BUS_P_W-BUS_FRAC-1:0] bus_shift;
  logic [MV_W-1:0]             bus_mv;

  always_comb begin
    bus_sum   = BUS_P_W'(in_q.adc_bus) * BUS_P_W'(vbus_scale_q) + BUS_ROUND;
    bus_shift = bus_sum[BUS_P_W-1:BUS_FRAC];
    if (!in_q.bus_ready) begin
      bus_mv = vbus_def_q;
    end else if (|bus_shift[BUS_P_W-BUS_FRAC-1:MV_W]) begin
      bus_mv = '1;
    end else begin
      bus_mv = bus_shift[MV_W-1:0];
    end
  end

  // -- hold of last valid set ------------------------------------------------------
  logic [CUR_W-1:0]  last_u_q, last_v_q, last_w_q;
  logic              last_valid_q;
  logic [HOLD_W-1:0] holds_q, holds_inc;
  logic              hold_now;

  assign hold_now  = in_q.fallback & last_valid_q;
  assign holds_inc = (holds_q == '1) ? holds_q : holds_q + HOLD_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q <= 1'b0;
      holds_q      <= '0;
    end else if (advance) begin
      case (in_q.func)
        FUNC_UPDATE: begin
          if (hold_now) begin
            holds_q <= holds_inc;
          end else begin
            holds_q      <= '0;
            last_valid_q <= 1'b1;
          end
        end
        FUNC_RESET: begin
          holds_q      <= '0;
          last_valid_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Held set is only read while last_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (advance && (in_q.func == FUNC_UPDATE) && !hold_now) begin
      last_u_q <= cur_u;
      last_v_q <= cur_v;
      last_w_q <= cur_w;
    end
  end

  // -- result ------------------------------------------------------------------------
  always_comb begin
    res_d = '0;
    case (in_q.func)
      FUNC_UPDATE: begin
        res_d.mv   = bus_mv;
        res_d.pair = pair;
        if (hold_now) begin
          res_d.cur_u      = last_u_q;
          res_d.cur_v      = last_v_q;
          res_d.cur_w      = last_w_q;
          res_d.held       = 1'b1;
          res_d.hold_count = holds_inc;
        end else begin
          res_d.cur_u = cur_u;
          res_d.cur_v = cur_v;
          res_d.cur_w = cur_w;
        end
      end
      FUNC_CALIB: res_d.calib_done = calib_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.current_u_ma = res_q.cur_u;
  assign out_o.current_v_ma = res_q.cur_v;
  assign out_o.current_w_ma = res_q.cur_w;
  assign out_o.bus_mv       = res_q.mv;
  assign out_o.trusted_pair = res_q.pair;
  assign out_o.held         = res_q.held;
  assign out_o.hold_count   = res_q.hold_count;
  assign out_o.calib_done   = res_q.calib_done;

endmodule

>>> rtl/tscr_phase.sv
// ----------------------------------------------------------------------------
// tscr_phase: one phase, ADC count to milliamps
// Offset removal, optional sign flip, Q16 scale, round, saturate to int16.
// ----------------------------------------------------------------------------
module tscr_phase import tscr_pkg::*; #(
  parameter int unsigned RAW_W = ADC_W,
  localparam int unsigned OFS_W = RAW_W + OFS_FRAC
) (
  input  logic [RAW_W-1:0]       raw_i,
  input  logic [OFS_W-1:0]       offset_i,
  input  logic                   invert_i,
  input  logic [SCALE_W-1:0]     scale_i,
  output logic signed [CUR_W-1:0] current_o
);

  localparam int unsigned DIFF_W = OFS_W + 2;
  localparam int unsigned PROD_W = DIFF_W + SCALE_W + 1;
  localparam int unsigned RND_W  = PROD_W + 1;
  localparam logic signed [RND_W-1:0] ROUND =
    {{(RND_W-CUR_FRAC){1'b0}}, 1'b1, {(CUR_FRAC-1){1'b0}}};

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] sdiff;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  quo;

  always_comb begin
    diff  = signed'({2'b00, raw_i, {OFS_FRAC{1'b0}}}) - signed'({2'b00, offset_i});
    sdiff = invert_i ? -diff : diff;
    prod  = PROD_W'(sdiff) * PROD_W'(signed'({1'b0, scale_i}));
    rnd   = RND_W'(prod) + ROUND;
    quo   = rnd >>> CUR_FRAC;   // floor division, also for negatives
    current_o = sat_cur(SAT_IN_W'(quo));
  end

endmodule

>>> rtl/tscr_calib.sv
// ----------------------------------------------------------------------------
// tscr_calib: zero-offset calibration
// Sums CALIB_SAMPLES raw counts per phase, then latches sum*16/N as offsets.
// ----------------------------------------------------------------------------
module tscr_calib import tscr_pkg::*; #(
  parameter int unsigned CALIB_SAMPLES = CALIB_SAMPLES_DEF,
  parameter int unsigned RAW_W         = ADC_W,
  localparam int unsigned OFS_W        = RAW_W + OFS_FRAC
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sample_i,
  input  logic [2:0][RAW_W-1:0] raw_i,
  output logic [2:0][OFS_W-1:0] offset_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES);
  localparam int unsigned SUM_W = RAW_W + CNT_W;
  localparam int unsigned NUM_W = SUM_W + OFS_FRAC;
  // Round-up reciprocal: exact floor(n/N) for every n below 2^NUM_W.
  localparam int unsigned DIV_S = NUM_W + CNT_W;
  localparam int unsigned MUL_W = NUM_W + 1;
  localparam int unsigned PRD_W = NUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_M =
    MUL_W'(((64'd1 << DIV_S) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W:0]   cnt_inc;
  logic             last;

  assign cnt_inc = {1'b0, count_q} + (CNT_W+1)'(1);
  assign last    = (cnt_inc == (CNT_W+1)'(CALIB_SAMPLES));
  assign count_d = last ? '0 : cnt_inc[CNT_W-1:0];
  assign done_o  = sample_i & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (sample_i) begin
      count_q <= count_d;
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_phase
    logic [SUM_W-1:0] sum_q, sum_d;
    logic [OFS_W-1:0] ofs_q;
    logic [PRD_W-1:0] prod;

    assign sum_d = sum_q + SUM_W'(raw_i[p]);
    assign prod  = PRD_W'({sum_d, {OFS_FRAC{1'b0}}}) * PRD_W'(DIV_M);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q <= '0;
        ofs_q <= '0;
      end else if (sample_i) begin
        if (last) begin
          sum_q <= '0;
          ofs_q <= prod[DIV_S +: OFS_W];
        end else begin
          sum_q <= sum_d;
        end
      end
    end

    assign offset_o[p] = ofs_q;
  end

endmodule
